FILE: design/awt_pkg.sv
// package for the atomic word table: request and response types and codes
package awt_pkg;

    // action codes
    localparam logic [3:0] ACT_LOAD  = 4'd0;
    localparam logic [3:0] ACT_STORE = 4'd1;
    localparam logic [3:0] ACT_XCHG  = 4'd2;
    localparam logic [3:0] ACT_CAS   = 4'd3;
    localparam logic [3:0] ACT_ADD   = 4'd4;
    localparam logic [3:0] ACT_SUB   = 4'd5;
    localparam logic [3:0] ACT_AND   = 4'd6;
    localparam logic [3:0] ACT_OR    = 4'd7;
    localparam logic [3:0] ACT_XOR   = 4'd8;
    localparam logic [3:0] ACT_GROW  = 4'd9;
    localparam logic [3:0] ACT_SIZE  = 4'd10;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_CAP   = 2'd2;

    // width of index and requested count fields
    localparam int IDX_W = 20;
    // width of the reported element count
    localparam int ECNT_W = 13;

    typedef struct packed {
        logic [3:0]         action;
        logic [IDX_W-1:0]   index;
        logic signed [63:0] operand;
        logic signed [63:0] expected;
        logic [IDX_W-1:0]   requested_count;
    } t_req;

    typedef struct packed {
        logic signed [63:0] old_value;
        logic [1:0]         status;
        logic [ECNT_W-1:0]  element_count;
    } t_rsp;

    // word write-back control from the execute logic
    typedef struct packed {
        logic        wr_en;
        logic [63:0] wr_data;
        logic        cnt_en;
    } t_upd;

endpackage

FILE: design/awt_exec.sv
// execute logic: range check, atomic operation and count update for one request
module awt_exec
    import awt_pkg::*;
#(
    parameter int CAPACITY = 4096
) (
    input  t_req                                i_req,
    input  logic [63:0]                         i_word,
    input  logic [$clog2(CAPACITY+1)-1:0]       i_count,
    output t_upd                                o_upd,
    output logic [$clog2(CAPACITY+1)-1:0]       o_count_nxt,
    output t_rsp                                o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = IDX_W + 1;

    logic          is_word;
    logic          is_grow;
    logic          in_range;
    logic          over_cap;
    logic          raise;
    logic          match;
    logic [63:0]   opnd;
    logic [63:0]   new_word;
    logic [XW-1:0] count_x;
    logic [XW-1:0] req_x;
    logic [CW-1:0] count_after;

    // classify the request
    assign count_x  = XW'(i_count);
    assign req_x    = XW'(i_req.requested_count);
    assign is_word  = (i_req.action <= ACT_XOR);
    assign is_grow  = (i_req.action == ACT_GROW);
    assign in_range = (XW'(i_req.index) < count_x);
    assign over_cap = (req_x > XW'(CAPACITY));
    assign raise    = is_grow && !over_cap && (req_x > count_x);

    // word operation
    assign opnd  = i_req.operand;
    assign match = (i_word == i_req.expected);

    always_comb begin
        case (i_req.action)
            ACT_STORE: new_word = opnd;
            ACT_XCHG:  new_word = opnd;
            ACT_CAS:   new_word = opnd;
            ACT_ADD:   new_word = i_word + opnd;
            ACT_SUB:   new_word = i_word - opnd;
            ACT_AND:   new_word = i_word & opnd;
            ACT_OR:    new_word = i_word | opnd;
            ACT_XOR:   new_word = i_word ^ opnd;
            default:   new_word = i_word;
        endcase
    end

    // write-back control
    assign o_upd.wr_en   = is_word && in_range && (i_req.action != ACT_LOAD)
                           && ((i_req.action != ACT_CAS) || match);
    assign o_upd.wr_data = new_word;
    assign o_upd.cnt_en  = raise;

    assign o_count_nxt = CW'(i_req.requested_count);
    assign count_after = raise ? CW'(i_req.requested_count) : i_count;

    // response
    always_comb begin
        o_rsp.old_value     = (is_word && in_range) ? i_word : 64'd0;
        o_rsp.element_count = ECNT_W'(count_after);
        if (is_grow && over_cap) begin
            o_rsp.status = ST_CAP;
        end else if (is_word && !in_range) begin
            o_rsp.status = ST_RANGE;
        end else begin
            o_rsp.status = ST_OK;
        end
    end

endmodule

FILE: design/atomic_word_table_top.sv
// atomic word table: table memory, request pipeline, forwarding and reset clear
// an accepted request is registered into the request stage, then its result strobe and response are registered
// throughput: one request per cycle while not busy; a same-word request that follows directly is forwarded
// reset: a clearing pass writes zero to all CAPACITY words, one per cycle, busy meanwhile
// the element count resets to zero; results cannot be stalled by the receiver
module atomic_word_table_top
    import awt_pkg::*;
#(
    parameter int CAPACITY = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [63:0]   mem [CAPACITY];
    logic [63:0]   r_rdata;

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic          r_s2_vld;
    t_req          r_s2_req;

    logic          r_fwd_vld;
    logic [AW-1:0] r_fwd_addr;
    logic [63:0]   r_fwd_data;

    logic [CW-1:0] r_count;
    logic          r_done;
    t_rsp          r_rsp;

    logic          accept;
    logic [AW-1:0] s2_addr;
    logic [63:0]   s2_word;
    t_upd          upd;
    logic [CW-1:0] count_nxt;
    t_rsp          rsp;
    logic          n_we;
    logic [AW-1:0] n_waddr;
    logic [63:0]   n_wdata;

    assign accept  = i_start && !r_clr_busy;
    assign s2_addr = r_s2_req.index[AW-1:0];

    // forward the write of the previous transfer when it hits the same word
    assign s2_word = (r_fwd_vld && (r_fwd_addr == s2_addr)) ? r_fwd_data : r_rdata;

    awt_exec #(
        .CAPACITY (CAPACITY)
    ) u_exec (
        .i_req       (r_s2_req),
        .i_word      (s2_word),
        .i_count     (r_count),
        .o_upd       (upd),
        .o_count_nxt (count_nxt),
        .o_rsp       (rsp)
    );

    // memory write port: clearing pass or write-back
    always_comb begin
        if (r_clr_busy) begin
            n_we    = 1'b1;
            n_waddr = r_clr_addr;
            n_wdata = 64'd0;
        end else begin
            n_we    = r_s2_vld && upd.wr_en;
            n_waddr = s2_addr;
            n_wdata = upd.wr_data;
        end
    end

    // table memory, read-first with registered read data
    always_ff @(posedge i_clk) begin
        if (n_we) begin
            mem[n_waddr] <= n_wdata;
        end
        r_rdata <= mem[i_req.index[AW-1:0]];
    end

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(CAPACITY - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // request stage and element count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
            r_done    <= 1'b0;
            r_count   <= '0;
        end else begin
            r_s2_vld  <= accept;
            r_fwd_vld <= r_s2_vld && upd.wr_en;
            r_done    <= r_s2_vld;
            if (r_s2_vld && upd.cnt_en) begin
                r_count <= count_nxt;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_req <= i_req;
        end
        r_fwd_addr <= s2_addr;
        r_fwd_data <= upd.wr_data;
        r_rsp      <= rsp;
    end

    assign o_busy = r_clr_busy;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

FILE: design/awt_check.sv
// port checker for the atomic word table and its bind to the top level
module awt_check
    import awt_pkg::*;
#(
    parameter int CAPACITY = 4096
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input t_req i_req,
    input logic o_busy,
    input logic o_done,
    input t_rsp o_rsp
);

    // every accepted transfer gives a result once it has passed the request stage and the result register
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |-> ##2 o_done)
        else $error("accepted request gave no result");

    // no result while the clearing pass runs
    a_quiet_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !o_done)
        else $error("result during clearing pass");

    // busy falls once after reset and stays low
    a_busy_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |=> !o_busy)
        else $error("busy rose without reset");

    // failed requests report no value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_rsp.status != ST_OK) |-> (o_rsp.old_value == 64'sd0))
        else $error("error status with nonzero value");

    // grow beyond capacity is flagged
    a_grow_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && (i_req.action == ACT_GROW)
        && (32'(i_req.requested_count) > CAPACITY)
        |-> ##2 (o_done && (o_rsp.status == ST_CAP)))
        else $error("grow beyond capacity not flagged");

endmodule

bind atomic_word_table_top awt_check #(.CAPACITY(CAPACITY)) u_awt_check (.*);
